>>> rtl/wrh_pkg.sv
package wrh_pkg;
  localparam int unsigned HistoryDepthDef = 80;
  localparam logic [31:0] WindowShortMs = 32'd1000;
  localparam logic [31:0] WindowLongMs = 32'd3000;

  localparam logic [1:0] FuncCapture = 2'd0;
  localparam logic [1:0] FuncRestart = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  localparam logic [1:0] ModeLive = 2'd0;
  localparam logic [1:0] ModeShort = 2'd1;
  localparam logic [1:0] ModeLong = 2'd2;

  localparam int unsigned RegAverageMode = 0;

  typedef struct packed {
    logic [1:0] func;
    logic [31:0] time_ms;
    logic [63:0] energy_total;
    logic [47:0] sample_total;
    logic [15:0] live_level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rms_level;
    logic from_history;
  } out_item_t;

  // Request to the divide / square-root unit and its answer.
  typedef struct packed {
    logic start;
    logic [70:0] e_sum;
    logic [38:0] s_sum;
  } root_req_t;

  typedef struct packed {
    logic done;
    logic [15:0] root;
  } root_rsp_t;
endpackage

>>> rtl/wrh_stream_if.sv
interface wrh_stream_if #(
  parameter int unsigned W = 1
);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wrh_mean_root.sv
module wrh_mean_root (
  input  logic clk,
  input  logic rst_n,
  input  wrh_pkg::root_req_t req,
  output wrh_pkg::root_rsp_t rsp
);
  import wrh_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StDone = 3'd3;

  logic [2:0] state_r, state_nxt;
  // Restoring divide of 4*E by S, quotient bits 31..0 only (others are zero
  // after the saturation check). Numerator shifted in MSB first.
  logic [72:0] num_r, num_nxt;
  logic [38:0] den_r, den_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic sat_r, sat_nxt;
  logic [31:0] sv_r, sv_nxt;
  logic [31:0] sres_r, sres_nxt;
  logic [31:0] sbit_r, sbit_nxt;
  logic [15:0] root_r, root_nxt;

  logic [39:0] rem_sh;
  logic [39:0] rem_sub;
  logic [31:0] trial;
  logic [72:0] num_in;

  assign num_in = {req.e_sum, 2'b00};
  assign rem_sh = {rem_r[38:0], num_r[72]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign trial = sres_r + sbit_r;

  always_comb begin
    state_nxt = state_r;
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    sat_nxt = sat_r;
    sv_nxt = sv_r;
    sres_nxt = sres_r;
    sbit_nxt = sbit_r;
    root_nxt = root_r;
    case (state_r)
      StIdle: begin
        if (req.start) begin
          num_nxt = num_in;
          den_nxt = req.s_sum;
          rem_nxt = '0;
          quo_nxt = '0;
          cnt_nxt = 7'd73;
          // Saturate when 4E >= S * 2^32.
          sat_nxt = (num_in[72:32] >= {2'b00, req.s_sum});
          state_nxt = StDiv;
        end
      end
      StDiv: begin
        if (rem_sub[39] == 1'b0) begin
          rem_nxt = rem_sub;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        num_nxt = {num_r[71:0], 1'b0};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = StSqrt;
          sres_nxt = '0;
          sbit_nxt = 32'h4000_0000;
          sv_nxt = quo_nxt;
        end
      end
      StSqrt: begin
        if (sbit_r == '0) begin
          root_nxt = sat_r ? 16'hFFFF : sres_r[15:0];
          state_nxt = StDone;
        end else begin
          if (sv_r >= trial) begin
            sv_nxt = sv_r - trial;
            sres_nxt = (sres_r >> 1) + sbit_r;
          end else begin
            sres_nxt = sres_r >> 1;
          end
          sbit_nxt = sbit_r >> 2;
        end
      end
      StDone: state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
    sv_r <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = (state_r == StDone);
  assign rsp.root = root_r;
endmodule

>>> rtl/windowed_rms_history.sv
// Windowed RMS history.
// Capture and restart finish at the accepting edge; a live query presents its beat in the
// next cycle, a windowed one after the bucket walk, the 73-step divide, the 16-step root
// and the handoff (divide and root are skipped when the window holds no samples).
// Throughput: one beat at a time; in_ready is low while a query is worked on.
// Reset (synchronous, rst_n low): ring emptied, totals and mode cleared; memory kept.
module windowed_rms_history #(
  parameter int unsigned HISTORY_DEPTH = wrh_pkg::HistoryDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  wrh_stream_if.sink in_ch,
  wrh_stream_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import wrh_pkg::*;

  localparam int unsigned IW = $clog2(HISTORY_DEPTH);
  localparam logic [6:0] DepthC = 7'(HISTORY_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(HISTORY_DEPTH - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StAcc = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  // Configuration: one register at address 0.
  logic [1:0] mode_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeLive;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == 2'(RegAverageMode * 4)) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == 2'(RegAverageMode * 4)) ? {30'd0, mode_r} : '0;

  // Bucket ring, one entry word: energy, samples, end time.
  logic [127:0] ring_mem [HISTORY_DEPTH];
  logic [127:0] rd_data_r;
  logic wr_en;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [127:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_idx] <= wr_data;
    end
    rd_data_r <= ring_mem[rd_idx];
  end

  logic [2:0] state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [IW-1:0] next_slot_r, next_slot_nxt;
  logic [6:0] filled_r, filled_nxt;
  logic [63:0] prior_e_r, prior_e_nxt;
  logic [47:0] prior_s_r, prior_s_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [6:0] left_r, left_nxt;
  logic [70:0] esum_r, esum_nxt;
  logic [38:0] ssum_r, ssum_nxt;
  out_item_t res_r, res_nxt;
  logic [31:0] window_r, window_nxt;
  root_req_t rreq;
  root_rsp_t rrsp;

  wrh_mean_root u_root (
    .clk (clk),
    .rst_n (rst_n),
    .req (rreq),
    .rsp (rrsp)
  );

  in_item_t in_beat;
  logic [63:0] de;
  logic [47:0] ds;
  logic drop;
  logic [IW-1:0] prev_idx;
  logic [31:0] age;

  assign in_beat = in_ch.data;
  assign in_ch.ready = (state_r == StIdle);
  assign out_ch.valid = (state_r == StOut);
  assign out_ch.data = res_r;

  assign de = in_beat.energy_total - prior_e_r;
  assign ds = in_beat.sample_total - prior_s_r;
  assign drop = (in_beat.sample_total < prior_s_r) ||
                (in_beat.energy_total < prior_e_r);
  assign prev_idx = (idx_r == '0) ? LastIdx : idx_r - IW'(1);
  assign age = item_r.time_ms - rd_data_r[31:0];

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    next_slot_nxt = next_slot_r;
    filled_nxt = filled_r;
    prior_e_nxt = prior_e_r;
    prior_s_nxt = prior_s_r;
    idx_nxt = idx_r;
    left_nxt = left_r;
    esum_nxt = esum_r;
    ssum_nxt = ssum_r;
    res_nxt = res_r;
    window_nxt = window_r;
    wr_en = 1'b0;
    wr_idx = next_slot_r;
    wr_data = {de, (ds[47:32] != '0) ? 32'hFFFF_FFFF : ds[31:0],
               in_beat.time_ms};
    rd_idx = prev_idx;
    rreq = '0;
    rreq.e_sum = esum_r;
    rreq.s_sum = ssum_r;
    case (state_r)
      StIdle: begin
        if (in_ch.valid) begin
          item_nxt = in_beat;
          case (in_beat.func)
            FuncCapture: begin
              prior_e_nxt = in_beat.energy_total;
              prior_s_nxt = in_beat.sample_total;
              if (drop) begin
                next_slot_nxt = '0;
                filled_nxt = '0;
              end else if (ds != '0) begin
                wr_en = 1'b1;
                next_slot_nxt = (next_slot_r == LastIdx) ? '0 : next_slot_r + IW'(1);
                if (filled_r < DepthC) filled_nxt = filled_r + 7'd1;
              end
            end
            FuncRestart: begin
              prior_e_nxt = in_beat.energy_total;
              prior_s_nxt = in_beat.sample_total;
              next_slot_nxt = '0;
              filled_nxt = '0;
            end
            FuncQuery: begin
              if (mode_r == ModeShort || mode_r == ModeLong) begin
                window_nxt = (mode_r == ModeShort) ? WindowShortMs : WindowLongMs;
                idx_nxt = next_slot_r;
                left_nxt = filled_r;
                esum_nxt = '0;
                ssum_nxt = '0;
                state_nxt = StRead;
              end else begin
                res_nxt.rms_level = in_beat.live_level;
                res_nxt.from_history = 1'b0;
                state_nxt = StOut;
              end
            end
            default: ;
          endcase
        end
      end
      // Issue the read of the next older bucket, or go to the root step when none is left.
      StRead: begin
        if (left_r == '0) begin
          state_nxt = StRoot;
        end else begin
          idx_nxt = prev_idx;
          left_nxt = left_r - 7'd1;
          state_nxt = StAcc;
        end
      end
      // Stop at the first bucket outside the window; else add it.
      StAcc: begin
        if (age >= window_r) begin
          state_nxt = StRoot;
        end else begin
          esum_nxt = esum_r + 71'(rd_data_r[127:64]);
          ssum_nxt = ssum_r + 39'(rd_data_r[63:32]);
          state_nxt = StRead;
        end
      end
      StRoot: begin
        if (ssum_r == '0) begin
          res_nxt.rms_level = item_r.live_level;
          res_nxt.from_history = 1'b0;
          state_nxt = StOut;
        end else begin
          rreq.start = 1'b1;
          state_nxt = StWait;
        end
      end
      StWait: begin
        if (rrsp.done) begin
          res_nxt.rms_level = rrsp.root;
          res_nxt.from_history = 1'b1;
          state_nxt = StOut;
        end
      end
      StOut: begin
        if (out_ch.ready) state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      next_slot_r <= '0;
      filled_r <= '0;
      prior_e_r <= '0;
      prior_s_r <= '0;
    end else begin
      state_r <= state_nxt;
      next_slot_r <= next_slot_nxt;
      filled_r <= filled_nxt;
      prior_e_r <= prior_e_nxt;
      prior_s_r <= prior_s_nxt;
    end
    item_r <= item_nxt;
    idx_r <= idx_nxt;
    left_r <= left_nxt;
    esum_r <= esum_nxt;
    ssum_r <= ssum_nxt;
    res_r <= res_nxt;
    window_r <= window_nxt;
  end
endmodule
